[rtl/dsts_pkg.sv]
// Shared types for the decision stump threshold sweep.
package dsts_pkg;

	// One weighted, labelled sample.
	typedef struct packed {
		logic signed [15:0] feature_value;
		logic               is_positive;
		logic [15:0]        weight;
		logic               last;
	} sample_t;

	// One trained stump.
	typedef struct packed {
		logic signed [15:0] threshold;
		logic               polarity_negative;
		logic [31:0]        best_error;
		logic [31:0]        total_weight;
		logic               order_fault;
	} stump_t;

	// Run totals and candidates captured on the last sample of a run.
	typedef struct packed {
		logic [31:0]        pos_sum;
		logic [31:0]        neg_sum;
		logic               boundary_seen;
		logic signed [32:0] diff_min;
		logic signed [32:0] diff_max;
		logic signed [15:0] thr_min;
		logic signed [15:0] thr_max;
		logic               max_first;
		logic signed [15:0] first_value;
		logic               fault;
	} snap_t;

endpackage

[rtl/dsts_accum.sv]
// Running weight sums and boundary tracking for one training run.
module dsts_accum #(
	parameter int MAX_SAMPLES = 65536,
	parameter int WEIGHT_BITS = 16,
	parameter int VALUE_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  dsts_pkg::sample_t item,
	output dsts_pkg::snap_t   snap
);

	localparam int VB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int IW = $clog2(MAX_SAMPLES);
	localparam logic [IW-1:0] IDX_MAX = IW'(MAX_SAMPLES - 1);

	logic               started_q;
	logic signed [15:0] first_q;
	logic signed [15:0] prev_q;
	logic [31:0]        pos_q;
	logic [31:0]        neg_q;
	logic               bseen_q;
	logic [IW-1:0]      count_q;
	logic signed [32:0] dmin_q;
	logic signed [32:0] dmax_q;
	logic signed [15:0] thr_min_q;
	logic signed [15:0] thr_max_q;
	logic [IW-1:0]      idx_min_q;
	logic [IW-1:0]      idx_max_q;
	logic               fault_q;

	logic               started_n;
	logic signed [15:0] first_n;
	logic signed [15:0] prev_n;
	logic [31:0]        pos_n;
	logic [31:0]        neg_n;
	logic               bseen_n;
	logic [IW-1:0]      count_n;
	logic signed [32:0] dmin_n;
	logic signed [32:0] dmax_n;
	logic signed [15:0] thr_min_n;
	logic signed [15:0] thr_max_n;
	logic [IW-1:0]      idx_min_n;
	logic [IW-1:0]      idx_max_n;
	logic               fault_n;

	logic signed [VB-1:0] v_raw;
	logic signed [15:0]   v;
	logic [31:0]          w;
	logic signed [32:0]   d;
	logic [32:0]          pos_add;
	logic [32:0]          neg_add;

	assign v_raw   = item.feature_value[VB-1:0];
	assign v       = 16'(v_raw);
	assign w       = 32'(item.weight[WB-1:0]);
	assign d       = $signed({1'b0, neg_q}) - $signed({1'b0, pos_q});
	assign pos_add = {1'b0, pos_q} + {1'b0, w};
	assign neg_add = {1'b0, neg_q} + {1'b0, w};

	always_comb begin
		started_n = started_q;
		first_n   = first_q;
		prev_n    = prev_q;
		pos_n     = pos_q;
		neg_n     = neg_q;
		bseen_n   = bseen_q;
		count_n   = count_q;
		dmin_n    = dmin_q;
		dmax_n    = dmax_q;
		thr_min_n = thr_min_q;
		thr_max_n = thr_max_q;
		idx_min_n = idx_min_q;
		idx_max_n = idx_max_q;
		fault_n   = fault_q;

		if (!started_q) begin
			started_n = 1'b1;
			first_n   = v;
			prev_n    = v;
		end else if (v < prev_q) begin
			fault_n = 1'b1;
			prev_n  = v;
		end else if (v > prev_q) begin
			// boundary: keep the earliest extreme of neg minus pos
			if (!bseen_q || d < dmin_q) begin
				dmin_n    = d;
				thr_min_n = v;
				idx_min_n = count_q;
			end
			if (!bseen_q || d > dmax_q) begin
				dmax_n    = d;
				thr_max_n = v;
				idx_max_n = count_q;
			end
			bseen_n = 1'b1;
			if (count_q < IDX_MAX) begin
				count_n = count_q + 1'b1;
			end
			prev_n = v;
		end

		if (item.is_positive) begin
			pos_n = pos_add[32] ? '1 : pos_add[31:0];
		end else begin
			neg_n = neg_add[32] ? '1 : neg_add[31:0];
		end
	end

	assign snap.pos_sum       = pos_n;
	assign snap.neg_sum       = neg_n;
	assign snap.boundary_seen = bseen_n;
	assign snap.diff_min      = dmin_n;
	assign snap.diff_max      = dmax_n;
	assign snap.thr_min       = thr_min_n;
	assign snap.thr_max       = thr_max_n;
	assign snap.max_first     = idx_max_n < idx_min_n;
	assign snap.first_value   = first_n;
	assign snap.fault         = fault_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			first_q   <= '0;
			prev_q    <= '0;
			pos_q     <= '0;
			neg_q     <= '0;
			bseen_q   <= 1'b0;
			count_q   <= '0;
			dmin_q    <= '0;
			dmax_q    <= '0;
			thr_min_q <= '0;
			thr_max_q <= '0;
			idx_min_q <= '0;
			idx_max_q <= '0;
			fault_q   <= 1'b0;
		end else if (go) begin
			if (item.last) begin
				// run done: start the next one clean
				started_q <= 1'b0;
				first_q   <= '0;
				prev_q    <= '0;
				pos_q     <= '0;
				neg_q     <= '0;
				bseen_q   <= 1'b0;
				count_q   <= '0;
				dmin_q    <= '0;
				dmax_q    <= '0;
				thr_min_q <= '0;
				thr_max_q <= '0;
				idx_min_q <= '0;
				idx_max_q <= '0;
				fault_q   <= 1'b0;
			end else begin
				started_q <= started_n;
				first_q   <= first_n;
				prev_q    <= prev_n;
				pos_q     <= pos_n;
				neg_q     <= neg_n;
				bseen_q   <= bseen_n;
				count_q   <= count_n;
				dmin_q    <= dmin_n;
				dmax_q    <= dmax_n;
				thr_min_q <= thr_min_n;
				thr_max_q <= thr_max_n;
				idx_min_q <= idx_min_n;
				idx_max_q <= idx_max_n;
				fault_q   <= fault_n;
			end
		end
	end

endmodule

[rtl/dsts_select.sv]
// Picks the lowest-error stump from the captured run totals.
module dsts_select (
	input  dsts_pkg::snap_t  snap,
	output dsts_pkg::stump_t stump
);

	logic [32:0]        total;
	logic signed [33:0] total_s;
	logic signed [33:0] ep;
	logic signed [33:0] em;
	logic               p_ok;
	logic               m_ok;
	logic               pick_plus;
	logic               pick_minus;
	logic signed [33:0] err;

	assign total   = {1'b0, snap.pos_sum} + {1'b0, snap.neg_sum};
	assign total_s = $signed({1'b0, total});
	assign ep      = $signed({2'b00, snap.pos_sum}) + 34'(snap.diff_min);
	assign em      = $signed({2'b00, snap.neg_sum}) - 34'(snap.diff_max);
	assign p_ok    = snap.boundary_seen && (ep < total_s);
	assign m_ok    = snap.boundary_seen && (em < total_s);

	always_comb begin
		pick_plus  = 1'b0;
		pick_minus = 1'b0;
		if (p_ok && m_ok) begin
			// tie goes to the earlier boundary, then to polarity +1
			if (em < ep || (em == ep && snap.max_first)) begin
				pick_minus = 1'b1;
			end else begin
				pick_plus = 1'b1;
			end
		end else if (p_ok) begin
			pick_plus = 1'b1;
		end else if (m_ok) begin
			pick_minus = 1'b1;
		end
	end

	always_comb begin
		err                     = total_s;
		stump.threshold         = snap.first_value;
		stump.polarity_negative = 1'b0;
		if (pick_plus) begin
			err             = ep;
			stump.threshold = snap.thr_min;
		end else if (pick_minus) begin
			err                     = em;
			stump.threshold         = snap.thr_max;
			stump.polarity_negative = 1'b1;
		end
		if (err < 0) begin
			stump.best_error = '0;
		end else if (err[33:32] != 2'b00) begin
			stump.best_error = '1;
		end else begin
			stump.best_error = err[31:0];
		end
		stump.total_weight = total[32] ? '1 : total[31:0];
		stump.order_fault  = snap.fault;
	end

endmodule

[rtl/decision_stump_threshold_sweep_top.sv]
// Decision stump trainer: sample register, run accumulator, selection and result register.
// Takes one sorted sample per clock while a last sample finds room downstream. A sample
// goes into an input register; the accumulator then folds it into the running weight sums
// and boundary extremes, and for the last sample of a run captures the run totals into a
// snapshot register, from which the result register takes the chosen stump. The block
// sustains one sample per cycle while results are drained. The single saturating add and
// compare on the running sums sets the per-sample cost.
module decision_stump_threshold_sweep_top #(
	parameter int MAX_SAMPLES = 65536,
	parameter int WEIGHT_BITS = 16,
	parameter int VALUE_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  dsts_pkg::sample_t sample,
	output logic              stump_valid,
	input  logic              stump_ready,
	output dsts_pkg::stump_t  stump
);

	logic              s1_valid_q;
	dsts_pkg::sample_t s1_q;
	logic              s2_valid_q;
	dsts_pkg::snap_t   s2_q;
	logic              out_valid_q;
	dsts_pkg::stump_t  out_q;

	dsts_pkg::snap_t   snap;
	dsts_pkg::stump_t  pick;

	logic out_free;
	logic s2_go;
	logic s2_free;
	logic s1_go;

	assign out_free     = !out_valid_q || stump_ready;
	assign s2_go        = s2_valid_q && out_free;
	assign s2_free      = !s2_valid_q || s2_go;
	// only a last word needs room downstream
	assign s1_go        = s1_valid_q && (!s1_q.last || s2_free);
	assign sample_ready = !s1_valid_q || s1_go;

	dsts_accum #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.item   (s1_q),
		.snap   (snap)
	);

	dsts_select u_select (
		.snap  (s2_q),
		.stump (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				s1_valid_q <= sample_valid;
			end
			if (s1_go && s1_q.last) begin
				s2_valid_q <= 1'b1;
			end else if (s2_go) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (stump_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			s1_q <= sample;
		end
		if (s1_go && s1_q.last) begin
			s2_q <= snap;
		end
		if (s2_go) begin
			out_q <= pick;
		end
	end

	assign stump_valid = out_valid_q;
	assign stump       = out_q;

endmodule

[rtl/dsts_checker.sv]
// Port-level checks for the decision stump trainer, bound to the top level.
module dsts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input dsts_pkg::sample_t sample,
	input logic              stump_valid,
	input logic              stump_ready,
	input dsts_pkg::stump_t  stump
);

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stump_valid && !stump_ready |=> stump_valid && $stable(stump))
		else $error("stalled stump word changed");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stump_valid |-> stump.best_error <= stump.total_weight)
		else $error("stump error above total weight");

	// polarity -1 only replaces the default when strictly better
	a_minus_better: assert property (@(posedge clk) disable iff (!arst_n)
		stump_valid && stump.polarity_negative |-> stump.best_error < stump.total_weight)
		else $error("negative polarity chosen without lower error");

	// hold a stalled sample word
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample))
		else $error("stalled sample word changed");

endmodule

bind decision_stump_threshold_sweep_top dsts_checker u_dsts_checker (.*);
